[hw/rtl/mcet_pkg.sv]
// mcet_pkg: request and result types, command and status structs, constants
// for the multi-channel event timer. No dependencies.
package mcet_pkg;

  localparam int KIND_W    = 2;
  localparam int CH_W      = 4;
  localparam int PERIOD_W  = 32;
  localparam int REP_W     = 16;
  localparam int TICK_W    = 29;
  localparam int CH_EXT_W  = 7;

  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ARM    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DISARM = 2'd2;

  // floor(x / 10) for 32-bit x is (x * ceil(2^35 / 10)) >> 35
  localparam logic [PERIOD_W-1:0] TICK_RECIP = 32'hCCCC_CCCD;
  localparam int                  TICK_SHIFT = 35;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [CH_W-1:0]     channel;
    logic [PERIOD_W-1:0] period_ms;
    logic                auto_reload;
    logic [REP_W-1:0]    repeat_count;
  } in_req_t;

  typedef struct packed {
    logic [CH_W-1:0] expired_channel;
    logic            finished;
    logic            last;
  } out_rsp_t;

  typedef struct packed {
    logic load;
    logic arm;
    logic disarm;
    logic scan_step;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic blocked;
    logic at_end;
    logic pend_valid;
    logic out_free;
  } dp_stat_t;

endpackage

[hw/rtl/mcet_ctrl.sv]
// mcet_ctrl: sequencer for arm, disarm and the per-tick channel scan
// depends on mcet_pkg
module mcet_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [mcet_pkg::KIND_W-1:0]  in_kind,
  input  mcet_pkg::dp_stat_t           stat,
  output logic                         in_stall,
  output mcet_pkg::dp_cmd_t            cmd
);
  import mcet_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_MUL   = 6'b000010,
    S_ARM   = 6'b000100,
    S_DIS   = 6'b001000,
    S_SCAN  = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          case (in_kind)
            KIND_ARM:    state_next = S_MUL;
            KIND_DISARM: state_next = S_DIS;
            KIND_TICK:   state_next = S_SCAN;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_MUL: begin
        state_next = S_ARM;
      end
      S_ARM: begin
        cmd.arm    = 1'b1;
        state_next = S_IDLE;
      end
      S_DIS: begin
        cmd.disarm = 1'b1;
        state_next = S_IDLE;
      end
      S_SCAN: begin
        cmd.scan_step = !stat.blocked;
        if (!stat.blocked && stat.at_end) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!stat.pend_valid) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/mcet_datapath.sv]
// mcet_datapath: request register, tick divider, channel tables, scan update,
// one-deep pending result and output register; depends on mcet_pkg
module mcet_datapath #(
  parameter int CHANNELS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  mcet_pkg::in_req_t  in_data,
  input  logic               out_stall,
  input  mcet_pkg::dp_cmd_t  cmd,
  output mcet_pkg::dp_stat_t stat,
  output logic               out_valid,
  output mcet_pkg::out_rsp_t out_data
);
  import mcet_pkg::*;

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  in_req_t                 item;
  logic [2*PERIOD_W-1:0]   prod;
  logic [TICK_W-1:0]       quot;
  logic [CH_EXT_W-1:0]     ch_ext;
  logic [CH_EXT_W-1:0]     idx_ext;
  logic                    ch_ok;
  logic [IW-1:0]           arm_idx;
  logic [IW-1:0]           idx;

  logic [TICK_W-1:0]       rem_tab [CHANNELS];
  logic [TICK_W-1:0]       rld_tab [CHANNELS];
  logic [REP_W-1:0]        rep_tab [CHANNELS];
  logic [CHANNELS-1:0]     mode_tab;
  logic [CHANNELS-1:0]     active;

  logic                    cur_act;
  logic                    cur_mode;
  logic [TICK_W-1:0]       cur_rem;
  logic [REP_W-1:0]        cur_rep;
  logic [TICK_W-1:0]       dec;
  logic                    hit;
  logic                    fin;
  logic                    retire;
  logic                    step_hit;
  logic                    push;

  logic                    pend_valid;
  logic [CH_W-1:0]         pend_ch;
  logic                    pend_fin;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
  end

  // ticks = period_ms / 10
  assign prod = item.period_ms * TICK_RECIP;

  always_ff @(posedge clk) begin
    quot <= prod[TICK_SHIFT +: TICK_W];
  end

  assign ch_ext  = CH_EXT_W'(item.channel);
  assign ch_ok   = ch_ext < CH_EXT_W'(CHANNELS);
  assign arm_idx = ch_ext[IW-1:0];
  assign idx_ext = CH_EXT_W'(idx);

  assign cur_act  = active[idx];
  assign cur_mode = mode_tab[idx];
  assign cur_rem  = rem_tab[idx];
  assign cur_rep  = rep_tab[idx];
  assign dec      = (cur_rem == '0) ? '0 : cur_rem - TICK_W'(1);
  assign hit      = cur_act && (dec == '0);
  assign fin      = hit && !cur_mode && (cur_rep == REP_W'(1));
  assign retire   = hit && !cur_mode && ((cur_rep == '0) || (cur_rep == REP_W'(1)));
  assign step_hit = cmd.scan_step && hit;

  always_ff @(posedge clk) begin
    if (cmd.arm && ch_ok) begin
      rem_tab[arm_idx]  <= quot;
      rld_tab[arm_idx]  <= quot;
      rep_tab[arm_idx]  <= item.repeat_count;
      mode_tab[arm_idx] <= (item.repeat_count == '0) ? item.auto_reload : 1'b0;
    end else if (cmd.scan_step && cur_act) begin
      if (!hit) begin
        rem_tab[idx] <= dec;
      end else if (cur_mode) begin
        rem_tab[idx] <= rld_tab[idx];
      end else if (cur_rep != '0) begin
        rep_tab[idx] <= cur_rep - REP_W'(1);
        rem_tab[idx] <= rld_tab[idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (cmd.arm && ch_ok) begin
      active[arm_idx] <= 1'b1;
    end else if (cmd.disarm && ch_ok) begin
      active[arm_idx] <= 1'b0;
    end else if (cmd.scan_step && retire) begin
      active[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.load) begin
      idx <= '0;
    end else if (cmd.scan_step) begin
      idx <= idx + IW'(1);
    end
  end

  // earlier expiry waits here until the next one shows it was not the last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (step_hit) begin
      pend_valid <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_hit) begin
      pend_ch  <= idx_ext[CH_W-1:0];
      pend_fin <= fin;
    end
  end

  assign stat.out_free   = !out_valid || !out_stall;
  assign stat.blocked    = hit && pend_valid && !stat.out_free;
  assign stat.at_end     = (idx == IW'(CHANNELS - 1));
  assign stat.pend_valid = pend_valid;

  assign push = (step_hit && pend_valid) || cmd.flush;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_data.expired_channel <= pend_ch;
      out_data.finished        <= pend_fin;
      out_data.last            <= cmd.flush;
    end
  end

endmodule

[hw/rtl/multi_channel_event_timer_unit.sv]
// Multi-channel event timer: an arm goes through idle, multiply and table write,
// a disarm through idle and clear; an unknown kind stays idle. A tick scans one
// table entry per cycle, stalling while an expiry or the final flush waits behind
// a held result. Each result is held until the next expiry of the tick or the end
// of the scan; the last one leaves from the flush state. Synchronous
// active-high reset clears active marks and control state; depends on mcet_pkg.
module multi_channel_event_timer_unit #(
  parameter int CHANNELS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  mcet_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mcet_pkg::out_rsp_t out_data
);
  import mcet_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mcet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  mcet_datapath #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[hw/rtl/mcet_checker.sv]
// mcet_checker: port-level checks on the event timer, bound to the top level
// depends on mcet_pkg and multi_channel_event_timer_unit
module mcet_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input mcet_pkg::in_req_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input mcet_pkg::out_rsp_t out_data
);
  import mcet_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a tick, arm or disarm keeps the block busy for at least the next cycle
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall &&
    (in_data.kind == KIND_TICK || in_data.kind == KIND_ARM ||
     in_data.kind == KIND_DISARM) |=> in_stall)
    else $error("request accepted without busy cycle");

  // results only come from a scan, never straight after acceptance
  a_no_result_on_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result raised right after request");

endmodule

bind multi_channel_event_timer_unit mcet_checker u_mcet_checker (.*);

[tb/testbench.sv]
// testbench: self-checking bench for multi_channel_event_timer_unit, predicting expiry
// results of the timer bank and checking them under sender gaps and receiver stalls.
// Depends on mcet_pkg and the multi_channel_event_timer_unit RTL.
module testbench;
  import mcet_pkg::*;

  localparam int NCH = 16;
  localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 3 * (NCH + 2);
  localparam int ITEMS_PER_PHASE = 64;
  localparam int MAX_PRINTED = 40;

  class timer_scoreboard;
    logic [TICK_W-1:0] ticks_left [NCH];
    logic [TICK_W-1:0] period_ticks [NCH];
    logic              reloading [NCH];
    logic [REP_W-1:0]  repeats_left [NCH];
    logic              armed [NCH];
    out_rsp_t          expiries [$];
    int                errors;

    function new();
      errors = 0;
      for (int c = 0; c < NCH; c++) begin
        ticks_left[c] = '0;
        period_ticks[c] = '0;
        reloading[c] = 1'b0;
        repeats_left[c] = '0;
        armed[c] = 1'b0;
      end
    endfunction

    function int pending();
      return expiries.size();
    endfunction

    function void note_request(in_req_t r);
      logic [PERIOD_W-1:0] divided;
      int                  start;
      out_rsp_t            rsp;
      start = expiries.size();
      case (r.kind)
        KIND_ARM: begin
          divided = r.period_ms / 10;
          ticks_left[r.channel] = divided[TICK_W-1:0];
          period_ticks[r.channel] = divided[TICK_W-1:0];
          repeats_left[r.channel] = r.repeat_count;
          reloading[r.channel] = (r.repeat_count == '0) ? r.auto_reload : 1'b0;
          armed[r.channel] = 1'b1;
        end
        KIND_DISARM: armed[r.channel] = 1'b0;
        KIND_TICK: begin
          for (int c = 0; c < NCH; c++) begin
            if (!armed[c]) continue;
            if (ticks_left[c] != '0) ticks_left[c] = ticks_left[c] - 1'b1;
            if (ticks_left[c] != '0) continue;
            rsp.expired_channel = CH_W'(c);
            rsp.finished = 1'b0;
            rsp.last = 1'b0;
            if (reloading[c]) begin
              ticks_left[c] = period_ticks[c];
            end else if (repeats_left[c] != '0) begin
              repeats_left[c] = repeats_left[c] - 1'b1;
              ticks_left[c] = period_ticks[c];
              if (repeats_left[c] == '0) begin
                rsp.finished = 1'b1;
                armed[c] = 1'b0;
              end
            end else begin
              armed[c] = 1'b0;
            end
            expiries.push_back(rsp);
          end
          if (expiries.size() > start) expiries[expiries.size() - 1].last = 1'b1;
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      if (errors < MAX_PRINTED) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(out_rsp_t got);
      out_rsp_t want;
      if (expiries.size() == 0) begin
        report($sformatf("unexpected expiry of channel %0d", got.expired_channel));
      end else begin
        want = expiries.pop_front();
        if (got.expired_channel != want.expired_channel)
          report($sformatf("expired_channel %0d, predicted %0d",
                           got.expired_channel, want.expired_channel));
        if (got.finished != want.finished)
          report($sformatf("finished %0b on channel %0d, predicted %0b",
                           got.finished, want.expired_channel, want.finished));
        if (got.last != want.last)
          report($sformatf("last %0b on channel %0d, predicted %0b",
                           got.last, want.expired_channel, want.last));
      end
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  out_rsp_t out_data;

  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  timer_scoreboard sb = new();

  multi_channel_event_timer_unit #(.CHANNELS(NCH)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result monitor and random back-pressure
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  task automatic send_request(input in_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(r);
  endtask

  task automatic issue(input logic [KIND_W-1:0] kind, input int ch,
                       input logic [PERIOD_W-1:0] period, input logic auto,
                       input logic [REP_W-1:0] rep);
    in_req_t r;
    r.kind = kind;
    r.channel = CH_W'(ch);
    r.period_ms = period;
    r.auto_reload = auto;
    r.repeat_count = rep;
    send_request(r);
  endtask

  function automatic in_req_t random_request();
    in_req_t r;
    int      pick;
    pick = $urandom_range(99);
    r.kind = (pick < 45) ? KIND_TICK : (pick < 78) ? KIND_ARM :
             (pick < 95) ? KIND_DISARM : KIND_RESERVED;
    r.channel = CH_W'($urandom_range(NCH - 1));
    r.auto_reload = 1'($urandom_range(1));
    if (r.kind == KIND_ARM) begin
      pick = $urandom_range(99);
      r.period_ms = (pick < 80) ? $urandom_range(60) :
                    (pick < 95) ? $urandom_range(300, 61) : $urandom();
      pick = $urandom_range(99);
      r.repeat_count = (pick < 60) ? '0 :
                       (pick < 95) ? REP_W'($urandom_range(4, 1)) : REP_W'($urandom());
    end else begin
      r.period_ms = $urandom();
      r.repeat_count = REP_W'($urandom());
    end
    return r;
  endfunction

  initial begin
    in_req_t r;
    int      counted;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    issue(KIND_TICK, 0, '0, 1'b0, '0);
    issue(KIND_ARM, 0, 32'd0, 1'b0, '0);
    issue(KIND_ARM, 1, 32'd9, 1'b1, '0);
    issue(KIND_ARM, 15, 32'd10, 1'b1, 16'd3);
    issue(KIND_ARM, 2, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    issue(KIND_ARM, 3, 32'd20, 1'b0, '0);
    issue(KIND_DISARM, 4, '0, 1'b0, '0);
    issue(KIND_RESERVED, 15, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    issue(KIND_TICK, 15, 32'hFFFF_FFFF, 1'b1, 16'hFFFF);
    issue(KIND_TICK, 0, '0, 1'b0, '0);
    issue(KIND_ARM, 1, 32'd50, 1'b0, 16'd2);
    issue(KIND_TICK, 0, '0, 1'b0, '0);
    issue(KIND_DISARM, 2, '0, 1'b0, '0);
    issue(KIND_ARM, 5, 32'd19, 1'b1, '0);
    issue(KIND_TICK, 0, '0, 1'b0, '0);
    issue(KIND_DISARM, 1, '0, 1'b0, '0);
    issue(KIND_TICK, 0, '0, 1'b0, '0);
    issue(KIND_DISARM, 5, '0, 1'b0, '0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 55; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      // every channel expiring on the same tick
      for (int c = 0; c < NCH; c++)
        issue(KIND_ARM, c, $urandom_range(9), 1'b0, '0);
      issue(KIND_TICK, 0, '0, 1'b0, '0);
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        r = random_request();
        send_request(r);
        if (r.kind != KIND_RESERVED) counted++;
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
